>>> rtl/core/slut_pkg.sv
// shared codes, widths and types of the sensor lookup table interpolator
`default_nettype none

package slut_pkg;

    localparam int ENTRY_INDEX_WIDTH = 5;
    localparam int LENGTH_WIDTH      = 6;
    localparam int CFG_INDEX_WIDTH   = 4;
    localparam int CFG_DATA_WIDTH    = 8;

    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_CONVERT = 1'b1;

    localparam logic MODE_FALLING = 1'b0;
    localparam logic MODE_RISING  = 1'b1;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_TABLE_LENGTH = 4'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_COEFF_MODE   = 4'd1;

    localparam logic [LENGTH_WIDTH-1:0] LENGTH_RESET = 6'd2;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

`default_nettype wire

>>> rtl/core/slut_table.sv
// breakpoint and mapped value table, one write port, one registered read port
`default_nettype none

module slut_table #(
    parameter int DEPTH = 32,
    parameter int AW    = 5,
    parameter int WIDTH = 40
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

>>> rtl/core/slut_div.sv
// restoring serial divider, one quotient bit per cycle
`default_nettype none

module slut_div #(
    parameter int NUM_W = 41,
    parameter int DEN_W = 24
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [NUM_W-1:0]  dividend,
    input  wire logic [DEN_W-1:0]  divisor,
    output logic      [NUM_W-1:0]  quotient,
    output slut_pkg::div_status_t  status
);

    localparam int CW = $clog2(NUM_W + 1);

    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   trial;
    logic             take;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[NUM_W-1]};
        take      = trial >= {1'b0, den_reg};
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            den_next  = divisor;
            quo_next  = dividend;
            cnt_next  = CW'(NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = take ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
            quo_next = {quo_reg[NUM_W-2:0], take};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

`default_nettype wire

>>> rtl/core/sensor_lut_interpolator.sv
// top level: table load, segment scan and interpolation of sensor readings
//
//   channel   direction  handshake                 payload
//   req       in         req_valid / req_stall     command, entry_index, breakpoint_value,
//                                                  mapped_value, measured_value
//   rsp       out        rsp_valid / rsp_stall     converted_value, out_of_range
//   cfg       in         cfg_valid / cfg_ready     cfg_index, cfg_data
//
// a load request is written to the table as it is taken; the table write port is the only resource
// a convert scans one entry per cycle, s = 1 to n - 1 steps for n entries in use, then divides;
// its result is posted after the divide, or without one when the reading equals the last breakpoint,
// and straight after the range check when it is out of range
// reset clears control and configuration only; table contents are undefined until loaded
// a finished result waits in the output register while the next request is taken
`default_nettype none

module sensor_lut_interpolator #(
    parameter int TABLE_DEPTH = 32,
    parameter int RAW_WIDTH   = 24,
    parameter int VALUE_WIDTH = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   req_valid,
    output logic                                        req_stall,
    input  wire logic                                   command,
    input  wire logic [slut_pkg::ENTRY_INDEX_WIDTH-1:0] entry_index,
    input  wire logic [RAW_WIDTH-1:0]                   breakpoint_value,
    input  wire logic signed [VALUE_WIDTH-1:0]          mapped_value,
    input  wire logic [RAW_WIDTH-1:0]                   measured_value,
    output logic                                        rsp_valid,
    input  wire logic                                   rsp_stall,
    output logic signed [VALUE_WIDTH-1:0]               converted_value,
    output logic                                        out_of_range,
    input  wire logic                                   cfg_valid,
    output logic                                        cfg_ready,
    input  wire logic [slut_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  wire logic [slut_pkg::CFG_DATA_WIDTH-1:0]    cfg_data
);

    localparam int AW = (TABLE_DEPTH > 2) ? $clog2(TABLE_DEPTH) : 1;
    localparam int EW = RAW_WIDTH + VALUE_WIDTH;
    localparam int MW = VALUE_WIDTH + 1;
    localparam int PW = RAW_WIDTH + MW;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIRST,
        ST_LAST,
        ST_SCAN,
        ST_MUL,
        ST_DIV,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;

    logic [slut_pkg::LENGTH_WIDTH-1:0] table_length_reg;
    logic                              coeff_mode_reg;

    logic [RAW_WIDTH-1:0]          meas_reg, meas_next;
    logic [RAW_WIDTH-1:0]          prev_bp_reg, prev_bp_next;
    logic signed [VALUE_WIDTH-1:0] prev_map_reg, prev_map_next;
    logic signed [VALUE_WIDTH-1:0] last_map_reg, last_map_next;
    logic [AW-1:0]                 idx_reg, idx_next;
    logic [RAW_WIDTH-1:0]          num_reg, num_next;
    logic [RAW_WIDTH-1:0]          den_reg, den_next;
    logic [MW-1:0]                 mag_reg, mag_next;
    logic                          neg_reg, neg_next;
    logic signed [VALUE_WIDTH-1:0] res_reg, res_next;
    logic                          err_reg, err_next;
    logic                          rsp_valid_reg, rsp_valid_next;
    logic signed [VALUE_WIDTH-1:0] conv_reg, conv_next;
    logic                          oor_reg, oor_next;

    logic                          req_fire;
    logic [31:0]                   idx_ext;
    logic [31:0]                   len_ext;
    logic [31:0]                   last_ext;
    logic [AW-1:0]                 last_idx;
    logic                          wr_en;
    logic [AW-1:0]                 rd_addr;
    logic [EW-1:0]                 rd_data;
    logic [RAW_WIDTH-1:0]          rd_bp;
    logic signed [VALUE_WIDTH-1:0] rd_map;
    logic                          rising;
    logic                          past;
    logic                          outside;
    logic signed [MW-1:0]          d_calc;
    logic [PW-1:0]                 product;
    logic [PW-1:0]                 quotient;
    logic [MW-1:0]                 q;
    logic signed [MW:0]            sum;
    logic                          div_start;
    slut_pkg::div_status_t         div_status;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_length_reg <= slut_pkg::LENGTH_RESET;
            coeff_mode_reg   <= slut_pkg::MODE_FALLING;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                slut_pkg::CFG_TABLE_LENGTH:
                    table_length_reg <= cfg_data[slut_pkg::LENGTH_WIDTH-1:0];
                slut_pkg::CFG_COEFF_MODE:
                    coeff_mode_reg <= cfg_data[0];
                default:
                    ;
            endcase
        end
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign req_fire  = req_valid && !req_stall;
    assign idx_ext   = 32'(entry_index);
    assign wr_en     = req_fire && (command == slut_pkg::CMD_LOAD)
                       && (idx_ext < 32'(TABLE_DEPTH));

    // clamp of the length in use
    assign len_ext = 32'(table_length_reg);

    always_comb
    begin
        if (len_ext < 32'd2)
        begin
            last_ext = 32'd1;
        end
        else if (len_ext > 32'(TABLE_DEPTH))
        begin
            last_ext = 32'(TABLE_DEPTH - 1);
        end
        else
        begin
            last_ext = len_ext - 32'd1;
        end
    end

    assign last_idx = last_ext[AW-1:0];

    always_comb
    begin
        unique case (state_reg)
            ST_IDLE:  rd_addr = '0;
            ST_FIRST: rd_addr = last_idx;
            ST_LAST:  rd_addr = AW'(1);
            ST_SCAN:  rd_addr = idx_reg + AW'(1);
            default:  rd_addr = '0;
        endcase
    end

    slut_table #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW),
        .WIDTH (EW)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (idx_ext[AW-1:0]),
        .wr_data ({breakpoint_value, mapped_value}),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_bp  = rd_data[EW-1:VALUE_WIDTH];
    assign rd_map = $signed(rd_data[VALUE_WIDTH-1:0]);
    assign rising = (coeff_mode_reg == slut_pkg::MODE_RISING);

    assign past    = rising ? (rd_bp > meas_reg) : (rd_bp < meas_reg);
    assign outside = rising ? (meas_reg < prev_bp_reg || meas_reg > rd_bp)
                            : (meas_reg > prev_bp_reg || meas_reg < rd_bp);
    assign d_calc  = $signed({rd_map[VALUE_WIDTH-1], rd_map})
                     - $signed({prev_map_reg[VALUE_WIDTH-1], prev_map_reg});

    assign product   = PW'(num_reg) * PW'(mag_reg);
    assign div_start = (state_reg == ST_MUL);

    slut_div #(
        .NUM_W (PW),
        .DEN_W (RAW_WIDTH)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (product),
        .divisor  (den_reg),
        .quotient (quotient),
        .status   (div_status)
    );

    assign q   = quotient[MW-1:0];
    assign sum = neg_reg ? ($signed({{2{res_reg[VALUE_WIDTH-1]}}, res_reg}) - $signed({1'b0, q}))
                         : ($signed({{2{res_reg[VALUE_WIDTH-1]}}, res_reg}) + $signed({1'b0, q}));

    always_comb
    begin
        state_next     = state_reg;
        meas_next      = meas_reg;
        prev_bp_next   = prev_bp_reg;
        prev_map_next  = prev_map_reg;
        last_map_next  = last_map_reg;
        idx_next       = idx_reg;
        num_next       = num_reg;
        den_next       = den_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        res_next       = res_reg;
        err_next       = err_reg;
        conv_next      = conv_reg;
        oor_next       = oor_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire && command == slut_pkg::CMD_CONVERT)
                begin
                    meas_next  = measured_value;
                    state_next = ST_FIRST;
                end
            end
            ST_FIRST:
            begin
                prev_bp_next  = rd_bp;
                prev_map_next = rd_map;
                state_next    = ST_LAST;
            end
            ST_LAST:
            begin
                last_map_next = rd_map;
                idx_next      = AW'(1);
                if (outside)
                begin
                    err_next   = 1'b1;
                    res_next   = '0;
                    state_next = ST_FINISH;
                end
                else
                begin
                    err_next   = 1'b0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (past)
                begin
                    // segment found: prev entry is its start
                    num_next   = rising ? (meas_reg - prev_bp_reg) : (prev_bp_reg - meas_reg);
                    den_next   = rising ? (rd_bp - prev_bp_reg) : (prev_bp_reg - rd_bp);
                    neg_next   = d_calc[MW-1];
                    mag_next   = d_calc[MW-1] ? MW'(-d_calc) : MW'(d_calc);
                    res_next   = prev_map_reg;
                    state_next = ST_MUL;
                end
                else if (idx_reg == last_idx)
                begin
                    res_next   = last_map_reg;
                    state_next = ST_FINISH;
                end
                else
                begin
                    prev_bp_next  = rd_bp;
                    prev_map_next = rd_map;
                    idx_next      = idx_reg + AW'(1);
                end
            end
            ST_MUL:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_status.done)
                begin
                    res_next   = sum[VALUE_WIDTH-1:0];
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    conv_next      = res_reg;
                    oor_next       = err_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        meas_reg     <= meas_next;
        prev_bp_reg  <= prev_bp_next;
        prev_map_reg <= prev_map_next;
        last_map_reg <= last_map_next;
        idx_reg      <= idx_next;
        num_reg      <= num_next;
        den_reg      <= den_next;
        mag_reg      <= mag_next;
        neg_reg      <= neg_next;
        res_reg      <= res_next;
        err_reg      <= err_next;
        conv_reg     <= conv_next;
        oor_reg      <= oor_next;
    end

    assign rsp_valid       = rsp_valid_reg;
    assign converted_value = conv_reg;
    assign out_of_range    = oor_reg;

    a_convert_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && command == slut_pkg::CMD_CONVERT |=> req_stall)
        else $error("convert request did not make the block busy");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && out_of_range |-> converted_value == '0)
        else $error("out of range result is not zero");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_status.done |-> state_reg == ST_DIV)
        else $error("divider finished outside the divide state");

    a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV && !div_status.done |-> div_status.busy)
        else $error("divider idle while a divide is awaited");

    a_rsp_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(state_reg == ST_FINISH))
        else $error("response raised without a finished convert");

endmodule

`default_nettype wire
